// ===== src/v2c_pkg.sv =====
// Shared types, constants and helpers for the vol2col address generator.
// No dependencies.
package v2c_pkg;

  localparam int DIM_WIDTH_DEF  = 16;
  localparam int ADDR_WIDTH_DEF = 32;
  localparam int KR_W           = 24;
  localparam int FLD_W          = 8;
  localparam int DIV_STEP       = 4;
  localparam int DIV_STAGES     = KR_W / DIV_STEP;
  localparam int QDEPTH         = 32;
  localparam int IDX_W          = 3;

  localparam logic [IDX_W-1:0] REG_VOLUME   = 3'd0;
  localparam logic [IDX_W-1:0] REG_FILTER   = 3'd1;
  localparam logic [IDX_W-1:0] REG_OUTPUT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_STRIDE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_DILATION = 3'd4;
  localparam logic [IDX_W-1:0] REG_PADS     = 3'd5;
  localparam logic [IDX_W-1:0] REG_LAYOUT   = 3'd6;

  typedef struct packed {
    logic [FLD_W-1:0] d;
    logic [FLD_W-1:0] h;
    logic [FLD_W-1:0] w;
  } triple_t;

  typedef struct packed {
    triple_t filt;
    triple_t stride;
    triple_t dil;
    triple_t pad;
  } geom_t;

  localparam triple_t TRIPLE_ONE  = '{d: 8'd1, h: 8'd1, w: 8'd1};
  localparam triple_t TRIPLE_ZERO = '{d: 8'd0, h: 8'd0, w: 8'd0};

  function automatic logic [FLD_W-1:0] nonzero8(input logic [FLD_W-1:0] v);
    return (v == '0) ? FLD_W'(1) : v;
  endfunction

endpackage

// ===== src/v2c_div.sv =====
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with sideband.
// Depends on v2c_pkg.
module v2c_div #(
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic [v2c_pkg::KR_W-1:0]  num,
  input  logic [v2c_pkg::FLD_W-1:0] den,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      out_vld,
  output logic [v2c_pkg::KR_W-1:0]  quo,
  output logic [v2c_pkg::FLD_W-1:0] rem,
  output logic [SIDE_W-1:0]         side_out
);
  import v2c_pkg::*;

  logic                vld_s  [0:DIV_STAGES];
  logic [KR_W-1:0]     num_s  [0:DIV_STAGES];
  logic [KR_W-1:0]     quo_s  [0:DIV_STAGES];
  logic [FLD_W-1:0]    rem_s  [0:DIV_STAGES];
  logic [SIDE_W-1:0]   side_s [0:DIV_STAGES];

  assign vld_s[0]  = in_vld;
  assign num_s[0]  = num;
  assign quo_s[0]  = '0;
  assign rem_s[0]  = '0;
  assign side_s[0] = side_in;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic              vld_r;
    logic [KR_W-1:0]   num_r, quo_r, num_nxt, quo_nxt;
    logic [FLD_W-1:0]  rem_r, rem_nxt;
    logic [SIDE_W-1:0] side_r;

    always_comb begin
      logic [FLD_W:0] t;
      num_nxt = num_s[s];
      quo_nxt = quo_s[s];
      rem_nxt = rem_s[s];
      for (int i = 0; i < DIV_STEP; i++) begin
        t       = {rem_nxt, num_nxt[KR_W-1]};
        num_nxt = {num_nxt[KR_W-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
          t       = t - {1'b0, den};
          quo_nxt = {quo_nxt[KR_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[KR_W-2:0], 1'b0};
        end
        rem_nxt = t[FLD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_s[s];
      end
      num_r  <= num_nxt;
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      side_r <= side_s[s];
    end

    assign vld_s[s+1]  = vld_r;
    assign num_s[s+1]  = num_r;
    assign quo_s[s+1]  = quo_r;
    assign rem_s[s+1]  = rem_r;
    assign side_s[s+1] = side_r;
  end

  assign out_vld  = vld_s[DIV_STAGES];
  assign quo      = quo_s[DIV_STAGES];
  assign rem      = rem_s[DIV_STAGES];
  assign side_out = side_s[DIV_STAGES];

endmodule

// ===== src/v2c_front.sv =====
// Front end: splits the kernel row by the filter sizes, forms the volume
// coordinate and classifies padding. Depends on v2c_pkg and v2c_div.
module v2c_front #(
  parameter int DIM_WIDTH = v2c_pkg::DIM_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  v2c_pkg::geom_t           geom,
  input  logic [DIM_WIDTH-1:0]     vd,
  input  logic [DIM_WIDTH-1:0]     vh,
  input  logic [DIM_WIDTH-1:0]     vw,
  input  logic                     in_vld,
  input  logic [v2c_pkg::KR_W-1:0] kr,
  input  logic [DIM_WIDTH-1:0]     oz,
  input  logic [DIM_WIDTH-1:0]     oy,
  input  logic [DIM_WIDTH-1:0]     ox,
  output logic                     it_vld,
  output logic [v2c_pkg::KR_W-1:0] it_kr,
  output logic [DIM_WIDTH-1:0]     it_oz,
  output logic [DIM_WIDTH-1:0]     it_oy,
  output logic [DIM_WIDTH-1:0]     it_ox,
  output logic [v2c_pkg::KR_W-1:0] it_c,
  output logic [DIM_WIDTH-1:0]     it_z,
  output logic [DIM_WIDTH-1:0]     it_y,
  output logic [DIM_WIDTH-1:0]     it_x,
  output logic                     it_pad
);
  import v2c_pkg::*;

  localparam int S1 = KR_W + 3 * DIM_WIDTH;
  localparam int S2 = S1 + FLD_W;
  localparam int S3 = S2 + FLD_W;
  localparam int PW = DIM_WIDTH + FLD_W;
  localparam int SW = DIM_WIDTH + 10;

  logic              v1, v2, v3;
  logic [KR_W-1:0]   q1, q2, q3;
  logic [FLD_W-1:0]  r1, r2, r3;
  logic [S1-1:0]     s1;
  logic [S2-1:0]     s2;
  logic [S3-1:0]     s3;

  v2c_div #(.SIDE_W(S1)) u_div_w (
    .clk, .rst_n, .in_vld(in_vld), .num(kr), .den(nonzero8(geom.filt.w)),
    .side_in({kr, oz, oy, ox}), .out_vld(v1), .quo(q1), .rem(r1), .side_out(s1)
  );

  v2c_div #(.SIDE_W(S2)) u_div_h (
    .clk, .rst_n, .in_vld(v1), .num(q1), .den(nonzero8(geom.filt.h)),
    .side_in({s1, r1}), .out_vld(v2), .quo(q2), .rem(r2), .side_out(s2)
  );

  v2c_div #(.SIDE_W(S3)) u_div_d (
    .clk, .rst_n, .in_vld(v2), .num(q2), .den(nonzero8(geom.filt.d)),
    .side_in({s2, r2}), .out_vld(v3), .quo(q3), .rem(r3), .side_out(s3)
  );

  logic [KR_W-1:0]      d_kr;
  logic [DIM_WIDTH-1:0] d_oz, d_oy, d_ox;
  logic [FLD_W-1:0]     w_off, h_off;

  assign {d_kr, d_oz, d_oy, d_ox, w_off, h_off} = s3;

  // coordinate stage
  logic                 cv_r;
  logic [KR_W-1:0]      ckr_r, cc_r;
  logic [DIM_WIDTH-1:0] coz_r, coy_r, cox_r;
  logic [SW-1:0]        zp_r, yp_r, xp_r;
  logic [PW-1:0]        pz, py, px;
  logic [2*FLD_W-1:0]   kz, ky, kx;

  assign pz = PW'(d_oz) * PW'(geom.stride.d);
  assign py = PW'(d_oy) * PW'(geom.stride.h);
  assign px = PW'(d_ox) * PW'(geom.stride.w);
  assign kz = (2*FLD_W)'(r3)    * (2*FLD_W)'(geom.dil.d);
  assign ky = (2*FLD_W)'(h_off) * (2*FLD_W)'(geom.dil.h);
  assign kx = (2*FLD_W)'(w_off) * (2*FLD_W)'(geom.dil.w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= v3;
    end
    ckr_r <= d_kr;
    cc_r  <= q3;
    coz_r <= d_oz;
    coy_r <= d_oy;
    cox_r <= d_ox;
    zp_r  <= SW'(pz) + SW'(kz) - SW'(geom.pad.d);
    yp_r  <= SW'(py) + SW'(ky) - SW'(geom.pad.h);
    xp_r  <= SW'(px) + SW'(kx) - SW'(geom.pad.w);
  end

  // padding stage
  logic pad_nxt;

  assign pad_nxt = zp_r[SW-1] || yp_r[SW-1] || xp_r[SW-1] ||
                   (zp_r >= SW'(vd)) || (yp_r >= SW'(vh)) || (xp_r >= SW'(vw));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_vld <= 1'b0;
    end else begin
      it_vld <= cv_r;
    end
    it_kr  <= ckr_r;
    it_oz  <= coz_r;
    it_oy  <= coy_r;
    it_ox  <= cox_r;
    it_c   <= cc_r;
    it_z   <= zp_r[DIM_WIDTH-1:0];
    it_y   <= yp_r[DIM_WIDTH-1:0];
    it_x   <= xp_r[DIM_WIDTH-1:0];
    it_pad <= pad_nxt;
  end

endmodule

// ===== src/v2c_queue.sv =====
// Small register FIFO between the front and back ends.
// Depends on nothing; depth must be a power of two.
module v2c_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W:0]   wp_r, rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
    end
    if (wr_en) mem_r[wp_r[PTR_W-1:0]] <= wr_data;
  end

  assign rd_data = mem_r[rp_r[PTR_W-1:0]];
  assign empty   = (wp_r == rp_r);

endmodule

// ===== src/v2c_mac.sv =====
// Three-step multiply-add chain: ((a*m1 + b)*m2 + c)*m3 + d, one register per step.
// No dependencies.
module v2c_mac #(
  parameter int A = 32,
  parameter int D = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [A-1:0] a,
  input  logic [A-1:0] b,
  input  logic [A-1:0] c,
  input  logic [A-1:0] d,
  input  logic [D-1:0] m1,
  input  logic [D-1:0] m2,
  input  logic [D-1:0] m3,
  output logic [A-1:0] y
);
  logic [A-1:0]   acc1_r, acc2_r, acc3_r, c1_r, d1_r, d2_r;
  logic [A+D-1:0] p1, p2, p3;

  assign p1 = (A+D)'(a)      * (A+D)'(m1);
  assign p2 = (A+D)'(acc1_r) * (A+D)'(m2);
  assign p3 = (A+D)'(acc2_r) * (A+D)'(m3);

  always_ff @(posedge clk) begin
    if (en) begin
      acc1_r <= p1[A-1:0] + b;
      c1_r   <= c;
      d1_r   <= d;
      acc2_r <= p2[A-1:0] + c1_r;
      d2_r   <= d1_r;
      acc3_r <= p3[A-1:0] + d2_r;
    end
  end

  assign y = acc3_r;

endmodule

// ===== src/v2c_back.sv =====
// Back end: pops classified beats and forms the column and volume addresses.
// Depends on v2c_pkg and v2c_mac.
module v2c_back #(
  parameter int DIM_WIDTH  = v2c_pkg::DIM_WIDTH_DEF,
  parameter int ADDR_WIDTH = v2c_pkg::ADDR_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [v2c_pkg::KR_W-1:0] q_kr,
  input  logic [DIM_WIDTH-1:0]     q_oz,
  input  logic [DIM_WIDTH-1:0]     q_oy,
  input  logic [DIM_WIDTH-1:0]     q_ox,
  input  logic [v2c_pkg::KR_W-1:0] q_c,
  input  logic [DIM_WIDTH-1:0]     q_z,
  input  logic [DIM_WIDTH-1:0]     q_y,
  input  logic [DIM_WIDTH-1:0]     q_x,
  input  logic                     q_pad,
  input  logic [DIM_WIDTH-1:0]     vc,
  input  logic [DIM_WIDTH-1:0]     vd,
  input  logic [DIM_WIDTH-1:0]     vh,
  input  logic [DIM_WIDTH-1:0]     vw,
  input  logic [DIM_WIDTH-1:0]     od,
  input  logic [DIM_WIDTH-1:0]     oh,
  input  logic [DIM_WIDTH-1:0]     ow,
  input  logic                     ch_last,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [ADDR_WIDTH-1:0]    out_col,
  output logic [ADDR_WIDTH-1:0]    out_vol,
  output logic                     out_pad
);
  import v2c_pkg::*;

  localparam int A = ADDR_WIDTH;

  logic [2:0]   v_r, pad_r;
  logic         adv;
  logic [A-1:0] va, vb, vcc, vdd, vol_y;
  logic [DIM_WIDTH-1:0] vm1, vm2, vm3;

  assign adv   = !(v_r[2] && out_stall);
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], q_pop};
    end
    if (adv) pad_r <= {pad_r[1:0], q_pad};
  end

  v2c_mac #(.A(A), .D(DIM_WIDTH)) u_col (
    .clk, .en(adv),
    .a(A'(q_kr)), .b(A'(q_oz)), .c(A'(q_oy)), .d(A'(q_ox)),
    .m1(od), .m2(oh), .m3(ow), .y(out_col)
  );

  always_comb begin
    if (ch_last) begin
      va = A'(q_z); vb = A'(q_y); vcc = A'(q_x); vdd = A'(q_c);
      vm1 = vh; vm2 = vw; vm3 = vc;
    end else begin
      va = A'(q_c); vb = A'(q_z); vcc = A'(q_y); vdd = A'(q_x);
      vm1 = vd; vm2 = vh; vm3 = vw;
    end
  end

  v2c_mac #(.A(A), .D(DIM_WIDTH)) u_vol (
    .clk, .en(adv),
    .a(va), .b(vb), .c(vcc), .d(vdd),
    .m1(vm1), .m2(vm2), .m3(vm3), .y(vol_y)
  );

  assign out_valid = v_r[2];
  assign out_pad   = pad_r[2];
  assign out_vol   = pad_r[2] ? '0 : vol_y;

endmodule

// ===== src/vol2col_address_generator.sv =====
// Top level of the vol2col address generator: config registers, front end,
// queue and back end. Depends on v2c_pkg, v2c_front, v2c_queue, v2c_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one column coordinate per beat:
//   kernel row and output z, y, x. Result channel (out_valid / out_stall):
//   column address, volume address and padding flag, one beat per input.
//   Config port: cfg_wr_en, cfg_index, cfg_wdata; write only while idle.
//   Pipeline: 18 divider stages, one coordinate stage, one padding stage,
//   queue write, three multiply-add stages. Throughput: one beat per cycle
//   while in_stall and out_stall are low, set by the fully pipelined
//   divider and multiply-add chains.
//   The front end never stalls; a credit count over front end plus queue
//   (32 entries) raises in_stall when the queue could overflow. A stalled
//   result holds its value and the back end freezes; the front end keeps
//   draining into the queue.
//   Reset clears all pipelines, the queue and the config registers to their
//   defaults (unit filter, stride and dilation, all else zero).
module vol2col_address_generator #(
  parameter int DIM_WIDTH  = v2c_pkg::DIM_WIDTH_DEF,
  parameter int ADDR_WIDTH = v2c_pkg::ADDR_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [v2c_pkg::KR_W-1:0]  in_kernel_row,
  input  logic [DIM_WIDTH-1:0]      in_out_z,
  input  logic [DIM_WIDTH-1:0]      in_out_y,
  input  logic [DIM_WIDTH-1:0]      in_out_x,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ADDR_WIDTH-1:0]     out_col_address,
  output logic [ADDR_WIDTH-1:0]     out_vol_address,
  output logic                      out_is_padding,
  input  logic                      cfg_wr_en,
  input  logic [v2c_pkg::IDX_W-1:0] cfg_index,
  input  logic [4*DIM_WIDTH-1:0]    cfg_wdata
);
  import v2c_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam int QW    = 2 * KR_W + 6 * DIM_WIDTH + 1;

  logic [4*DIM_WIDTH-1:0] volume_r;
  logic [3*DIM_WIDTH-1:0] output_r;
  geom_t                  geom_r;
  logic                   layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r      <= '0;
      output_r      <= '0;
      geom_r.filt   <= TRIPLE_ONE;
      geom_r.stride <= TRIPLE_ONE;
      geom_r.dil    <= TRIPLE_ONE;
      geom_r.pad    <= TRIPLE_ZERO;
      layout_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_VOLUME:   volume_r      <= cfg_wdata;
        REG_FILTER:   geom_r.filt   <= cfg_wdata[3*FLD_W-1:0];
        REG_OUTPUT:   output_r      <= cfg_wdata[3*DIM_WIDTH-1:0];
        REG_STRIDE:   geom_r.stride <= cfg_wdata[3*FLD_W-1:0];
        REG_DILATION: geom_r.dil    <= cfg_wdata[3*FLD_W-1:0];
        REG_PADS:     geom_r.pad    <= cfg_wdata[3*FLD_W-1:0];
        REG_LAYOUT:   layout_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [DIM_WIDTH-1:0] vw, vh, vd, vc, ow, oh, od;

  assign {vc, vd, vh, vw} = volume_r;
  assign {od, oh, ow}     = output_r;

  // credits over front end plus queue
  logic [CNT_W-1:0] cnt_r;
  logic             acc, pop;

  assign in_stall = (cnt_r == CNT_W'(QDEPTH));
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CNT_W'(acc) - CNT_W'(pop);
    end
  end

  logic                 f_vld, f_pad;
  logic [KR_W-1:0]      f_kr, f_c;
  logic [DIM_WIDTH-1:0] f_oz, f_oy, f_ox, f_z, f_y, f_x;

  v2c_front #(.DIM_WIDTH(DIM_WIDTH)) u_front (
    .clk, .rst_n, .geom(geom_r), .vd, .vh, .vw,
    .in_vld(acc), .kr(in_kernel_row), .oz(in_out_z), .oy(in_out_y), .ox(in_out_x),
    .it_vld(f_vld), .it_kr(f_kr), .it_oz(f_oz), .it_oy(f_oy), .it_ox(f_ox),
    .it_c(f_c), .it_z(f_z), .it_y(f_y), .it_x(f_x), .it_pad(f_pad)
  );

  logic [QW-1:0]        q_data;
  logic                 q_empty, q_pad;
  logic [KR_W-1:0]      q_kr, q_c;
  logic [DIM_WIDTH-1:0] q_oz, q_oy, q_ox, q_z, q_y, q_x;

  v2c_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .wr_en(f_vld),
    .wr_data({f_kr, f_oz, f_oy, f_ox, f_c, f_z, f_y, f_x, f_pad}),
    .rd_en(pop), .rd_data(q_data), .empty(q_empty)
  );

  assign {q_kr, q_oz, q_oy, q_ox, q_c, q_z, q_y, q_x, q_pad} = q_data;

  v2c_back #(.DIM_WIDTH(DIM_WIDTH), .ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk, .rst_n, .q_empty, .q_pop(pop),
    .q_kr, .q_oz, .q_oy, .q_ox, .q_c, .q_z, .q_y, .q_x, .q_pad,
    .vc, .vd, .vh, .vw, .od, .oh, .ow, .ch_last(layout_r),
    .out_stall, .out_valid, .out_col(out_col_address),
    .out_vol(out_vol_address), .out_pad(out_is_padding)
  );

endmodule

// ===== src/v2c_checker.sv =====
// Port-level checks for the vol2col address generator, bound to the top level.
// Depends on vol2col_address_generator.
module v2c_checker #(
  parameter int ADDR_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ADDR_WIDTH-1:0] out_col_address,
  input logic [ADDR_WIDTH-1:0] out_vol_address,
  input logic                  out_is_padding
);

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_padding |-> out_vol_address == '0)
    else $error("padding beat with nonzero volume address");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_col_address) && $stable(out_vol_address)
                               && $stable(out_is_padding))
    else $error("stalled result changed");

endmodule

bind vol2col_address_generator v2c_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_v2c_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_col_address, .out_vol_address,
  .out_is_padding
);

// ===== tb/vol2col_address_generator_test.sv =====
// Testbench for vol2col_address_generator: drives column coordinates through
// several register settings and checks each result against a built-in predictor.
// Depends on v2c_pkg and the block's RTL.
module vol2col_address_generator_test;
  import v2c_pkg::*;

  localparam int DW = 16;
  localparam int AW = 32;
  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [KR_W-1:0] kr;
    logic [DW-1:0] z;
    logic [DW-1:0] y;
    logic [DW-1:0] x;
  } coord_t;

  typedef struct {
    logic [AW-1:0] col;
    logic [AW-1:0] vol;
    logic pad;
  } addr_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [KR_W-1:0] in_kernel_row = '0;
  logic [DW-1:0] in_out_z = '0, in_out_y = '0, in_out_x = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [AW-1:0] out_col_address, out_vol_address;
  logic out_is_padding;
  logic cfg_wr_en = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [4*DW-1:0] cfg_wdata = '0;

  vol2col_address_generator DUT (.*);

  always #4 clk = ~clk;

  logic [63:0] vol_shape;
  logic [23:0] filt_shape, stride_v, dil_v, pads_v;
  logic [47:0] outp_shape;
  logic layout_last;

  coord_t pending[$];
  addr_t expected[$];
  int errors = 0;
  int idle_pct = 8;
  int hold_off = 0;
  int sender_pause = 0;
  int quiet = 0;

  function automatic addr_t predict_addr(coord_t c);
    addr_t r;
    longint unsigned kr, fw, fh, fd, woff, hoff, doff, cin, col, vol;
    longint unsigned vw, vh, vd, vc, ow, oh, od;
    longint zp, yp, xp;
    kr = c.kr;
    vw = vol_shape[15:0]; vh = vol_shape[31:16]; vd = vol_shape[47:32];
    vc = vol_shape[63:48];
    ow = outp_shape[15:0]; oh = outp_shape[31:16]; od = outp_shape[47:32];
    fw = filt_shape[7:0] == 0 ? 1 : filt_shape[7:0];
    fh = filt_shape[15:8] == 0 ? 1 : filt_shape[15:8];
    fd = filt_shape[23:16] == 0 ? 1 : filt_shape[23:16];
    woff = kr % fw;
    hoff = (kr / fw) % fh;
    doff = (kr / fw / fh) % fd;
    cin = kr / fw / fh / fd;
    zp = longint'(c.z) * stride_v[23:16] - pads_v[23:16] + longint'(doff) * dil_v[23:16];
    yp = longint'(c.y) * stride_v[15:8] - pads_v[15:8] + longint'(hoff) * dil_v[15:8];
    xp = longint'(c.x) * stride_v[7:0] - pads_v[7:0] + longint'(woff) * dil_v[7:0];
    r.pad = zp < 0 || yp < 0 || xp < 0 || zp >= longint'(vd) || yp >= longint'(vh)
            || xp >= longint'(vw);
    col = ((kr * od + c.z) * oh + c.y) * ow + c.x;
    vol = 0;
    if (!r.pad) begin
      if (layout_last)
        vol = ((longint'(zp) * vh + yp) * vw + xp) * vc + cin;
      else
        vol = ((cin * vd + zp) * vh + yp) * vw + xp;
    end
    r.col = col[AW-1:0];
    r.vol = vol[AW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [AW-1:0] got, logic [AW-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) expected.push_back(predict_addr('{in_kernel_row, in_out_z, in_out_y,
                                                     in_out_x}));
      if (pending.size() > 0 && sender_pause == 0 &&
          $urandom_range(99, 0) >= idle_pct) begin
        coord_t c;
        c = pending.pop_front();
        in_valid <= 1;
        in_kernel_row <= c.kr;
        in_out_z <= c.z;
        in_out_y <= c.y;
        in_out_x <= c.x;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected.size() == 0) begin
        $display("unexpected result beat");
        errors++;
      end else begin
        addr_t e;
        e = expected.pop_front();
        if (out_col_address !== e.col) report_mismatch("col_address", out_col_address, e.col);
        if (out_vol_address !== e.vol) report_mismatch("vol_address", out_vol_address, e.vol);
        if (out_is_padding !== e.pad) report_mismatch("is_padding", out_is_padding, e.pad);
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_VOLUME: vol_shape = v;
      REG_FILTER: filt_shape = v[23:0];
      REG_OUTPUT: outp_shape = v[47:0];
      REG_STRIDE: stride_v = v[23:0];
      REG_DILATION: dil_v = v[23:0];
      REG_PADS: pads_v = v[23:0];
      REG_LAYOUT: layout_last = v[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic drain;
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mx);
    coord_t c;
    c.kr = KR_W'($urandom_range(mx * 8, 0));
    c.z = DW'($urandom_range(mx, 0));
    c.y = DW'($urandom_range(mx, 0));
    c.x = DW'($urandom_range(mx, 0));
    return c;
  endfunction

  initial begin
    vol_shape = 0; filt_shape = 24'h010101; outp_shape = 0;
    stride_v = 24'h010101; dil_v = 24'h010101; pads_v = 0; layout_last = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed: reset defaults, zero volume => all padding
    pending.push_back('{24'h0, 16'h0, 16'h0, 16'h0});
    pending.push_back('{24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();
    write_reg(REG_VOLUME, {16'd3, 16'd5, 16'd6, 16'd7});
    write_reg(REG_FILTER, 64'h030303);
    write_reg(REG_OUTPUT, 64'({16'd5, 16'd6, 16'd7}));
    write_reg(REG_PADS, 64'h010101);
    for (int i = 0; i < 10; i++) pending.push_back(rand_coord(8));
    pending.push_back('{24'd80, 16'd0, 16'd0, 16'd0});
    pending.push_back('{24'hFFFFFF, 16'd1, 16'd1, 16'd1});
    drain();
    write_reg(REG_LAYOUT, 64'd1);
    write_reg(REG_FILTER, 64'h0);
    write_reg(REG_STRIDE, 64'h0);
    write_reg(REG_DILATION, 64'h0);
    write_reg(IDX_W'(7), 64'hFFFF);
    for (int i = 0; i < 8; i++) pending.push_back(rand_coord(6));
    drain();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      int mx;
      write_reg(REG_VOLUME, ph == 5 ? 64'hFFFFFFFFFFFFFFFF :
                {16'($urandom_range(6, 1)), 16'($urandom_range(12, 1)),
                 16'($urandom_range(12, 1)), 16'($urandom_range(12, 1))});
      write_reg(REG_FILTER, ph == 5 ? 64'hFFFFFF : 64'($urandom_range(24'h050505, 0)));
      write_reg(REG_OUTPUT, ph == 5 ? 64'hFFFFFFFFFFFF :
                64'({16'($urandom_range(12, 1)), 16'($urandom_range(12, 1)),
                     16'($urandom_range(12, 1))}));
      write_reg(REG_STRIDE, ph == 5 ? 64'hFFFFFF : 64'($urandom_range(24'h030303, 0)));
      write_reg(REG_DILATION, ph == 5 ? 64'hFFFFFF : 64'($urandom_range(24'h030303, 0)));
      write_reg(REG_PADS, ph == 5 ? 64'hFFFFFF : 64'($urandom_range(24'h030303, 0)));
      write_reg(REG_LAYOUT, 64'(ph & 1));
      mx = (ph == 5) ? 65535 : 14;
      idle_pct = (ph == 2) ? 0 : 8;
      for (int i = 0; i < 170; i++) begin
        coord_t c;
        c = rand_coord(mx);
        if ($urandom_range(9, 0) == 0) begin
          c.kr = KR_W'($urandom); c.z = DW'($urandom);
          c.y = DW'($urandom); c.x = DW'($urandom);
        end
        pending.push_back(c);
      end
      if (ph == 1) begin
        @(posedge clk);
        hold_off <= 200;
      end
      if (ph == 3) begin
        while (pending.size() > 85) @(posedge clk);
        sender_pause = 1;
        while (in_valid || expected.size() > 0) @(posedge clk);
        sender_pause = 0;
      end
      drain();
    end

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
src/v2c_pkg.sv
src/v2c_div.sv
src/v2c_front.sv
src/v2c_queue.sv
src/v2c_mac.sv
src/v2c_back.sv
src/vol2col_address_generator.sv
src/v2c_checker.sv
tb/vol2col_address_generator_test.sv
